// ===== rtl/date_validate_and_day_difference_macros.svh =====
// ----------------------------------------------------------------------------
// date validate and day difference: assertion macros
// concurrent checks sampled on clk, switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef DATE_VALIDATE_AND_DAY_DIFFERENCE_MACROS_SVH
`define DATE_VALIDATE_AND_DAY_DIFFERENCE_MACROS_SVH

// same-cycle implication
`define DVDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dvdd_pkg.sv =====
// ----------------------------------------------------------------------------
// dvdd_pkg
// shared types, constants and the month length function
// ----------------------------------------------------------------------------
package dvdd_pkg;

  localparam logic [11:0] BASE_YEAR = 12'd1900;
  localparam int unsigned MAX_YEAR  = 4095;
  // 1900 mod 400
  localparam logic [8:0]  BASE_MOD400 = 9'd300;

  localparam int unsigned ACC_W = 21;
  localparam int unsigned OPD_W = 9;

  typedef struct packed {
    logic [5:0]  a_day;
    logic [3:0]  a_month;
    logic [11:0] a_year;
    logic [5:0]  b_day;
    logic [3:0]  b_month;
    logic [11:0] b_year;
  } item_t;

  typedef struct packed {
    logic signed [20:0] day_difference;
    logic [2:0]         a_fixups;
    logic [2:0]         b_fixups;
  } result_t;

  // control of the shared accumulator
  typedef struct packed {
    logic             clear;
    logic             en;
    logic             sub;
    logic [OPD_W-1:0] operand;
  } acc_ctrl_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dvdd_acc.sv =====
// ----------------------------------------------------------------------------
// dvdd_acc
// shared add/subtract accumulator, one operand per cycle, wraps at 21 bits
// ----------------------------------------------------------------------------
module dvdd_acc (
  input  logic                             clk,
  input  logic                             rst,
  input  dvdd_pkg::acc_ctrl_t              ctrl,
  output logic [dvdd_pkg::ACC_W-1:0]       acc
);

  logic [dvdd_pkg::ACC_W-1:0] opd;
  logic [dvdd_pkg::ACC_W-1:0] acc_next;

  assign opd = {{(dvdd_pkg::ACC_W - dvdd_pkg::OPD_W){1'b0}}, ctrl.operand};

  always_comb begin
    acc_next = acc;
    if (ctrl.clear) begin
      acc_next = '0;
    end else if (ctrl.en) begin
      acc_next = ctrl.sub ? (acc - opd) : (acc + opd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/dvdd_seq.sv =====
// ----------------------------------------------------------------------------
// dvdd_seq
// sequencer: corrects each date, walks years then months, adds the day, drives the accumulator
// ----------------------------------------------------------------------------
`include "date_validate_and_day_difference_macros.svh"

module dvdd_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  dvdd_pkg::item_t           item,
  input  logic                      out_free,
  input  logic [dvdd_pkg::ACC_W-1:0] acc,
  output dvdd_pkg::acc_ctrl_t       ctrl,
  output logic                      busy,
  output logic                      done,
  output dvdd_pkg::result_t         res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIX   = 3'd1;
  localparam logic [2:0] S_YEAR  = 3'd2;
  localparam logic [2:0] S_MONTH = 3'd3;
  localparam logic [2:0] S_DAY   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state;
  dvdd_pkg::item_t held;
  logic            side;
  logic [11:0]     y;
  logic [3:0]      m;
  logic [5:0]      d;
  logic [11:0]     yc;
  logic [6:0]      c100;
  logic [8:0]      c400;
  logic [3:0]      mi;
  logic [1:0]      fix_lo;
  logic [2:0]      fix_a;
  logic [2:0]      fix_b;

  logic [5:0]  raw_d;
  logic [3:0]  raw_m;
  logic [11:0] raw_y;
  logic        leap;
  logic [4:0]  dim_m;
  logic [4:0]  dim_mi;
  logic        day_bad;

  assign raw_d = side ? held.b_day   : held.a_day;
  assign raw_m = side ? held.b_month : held.a_month;
  assign raw_y = side ? held.b_year  : held.a_year;

  // leap test from running year, mod 100 and mod 400 counters
  assign leap    = (yc[1:0] == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
  assign dim_m   = dvdd_pkg::days_in_month(m, leap);
  assign dim_mi  = dvdd_pkg::days_in_month(mi, leap);
  assign day_bad = (d == 6'd0) || (d > {1'b0, dim_m});

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE) && out_free;

  assign res.day_difference = acc;
  assign res.a_fixups       = fix_a;
  assign res.b_fixups       = fix_b;

  always_comb begin
    ctrl.clear   = start;
    ctrl.en      = 1'b0;
    ctrl.sub     = side;
    ctrl.operand = '0;
    unique case (state)
      S_YEAR: begin
        if (yc != y) begin
          ctrl.en      = 1'b1;
          ctrl.operand = 9'd365 + {8'd0, leap};
        end
      end
      S_MONTH: begin
        if (mi != m) begin
          ctrl.en      = 1'b1;
          ctrl.operand = {4'd0, dim_mi};
        end
      end
      S_DAY: begin
        ctrl.en      = 1'b1;
        ctrl.operand = day_bad ? 9'd1 : {3'd0, d};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            held  <= item;
            side  <= 1'b0;
            state <= S_FIX;
          end
        end
        S_FIX: begin
          d <= raw_d;
          if ((raw_m == 4'd0) || (raw_m > 4'd12)) begin
            m         <= 4'd1;
            fix_lo[0] <= 1'b1;
          end else begin
            m         <= raw_m;
            fix_lo[0] <= 1'b0;
          end
          if (raw_y < dvdd_pkg::BASE_YEAR) begin
            y         <= dvdd_pkg::BASE_YEAR;
            fix_lo[1] <= 1'b1;
          end else if ({1'b0, raw_y} > 13'(dvdd_pkg::MAX_YEAR)) begin
            y         <= 12'(dvdd_pkg::MAX_YEAR);
            fix_lo[1] <= 1'b1;
          end else begin
            y         <= raw_y;
            fix_lo[1] <= 1'b0;
          end
          yc    <= dvdd_pkg::BASE_YEAR;
          c100  <= 7'd0;
          c400  <= dvdd_pkg::BASE_MOD400;
          state <= S_YEAR;
        end
        S_YEAR: begin
          if (yc == y) begin
            mi    <= 4'd1;
            state <= S_MONTH;
          end else begin
            yc   <= yc + 12'd1;
            c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
            c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
          end
        end
        S_MONTH: begin
          if (mi == m) begin
            state <= S_DAY;
          end else begin
            mi <= mi + 4'd1;
          end
        end
        S_DAY: begin
          if (side) begin
            fix_b <= {day_bad, fix_lo};
            state <= S_DONE;
          end else begin
            fix_a <= {day_bad, fix_lo};
            side  <= 1'b1;
            state <= S_FIX;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DVDD_ASSERT_NOW(a_start_idle, start, state == S_IDLE, "item taken while busy")
  `DVDD_ASSERT_NOW(a_year_bound, state == S_YEAR, yc <= y, "year walk passed target")
  `DVDD_ASSERT_NOW(a_month_bound, state == S_MONTH, (mi <= m) && (mi != 4'd0),
                   "month walk out of range")
  `DVDD_ASSERT_NOW(a_mod_ctr, state == S_YEAR, (c100 < 7'd100) && (c400 < 9'd400),
                   "leap counters out of range")
  `DVDD_ASSERT_NEXT(a_done_idle, done, state == S_IDLE, "no return to idle after result")

endmodule

// ===== rtl/date_validate_and_day_difference.sv =====
// ----------------------------------------------------------------------------
// date_validate_and_day_difference
// Two raw Gregorian dates come in on the item channel as one transfer. Each
// date has month, year and day corrected to defaults where out of range,
// then is turned into a day number counted from 1 Jan 1900. One result
// transfer returns A minus B (21-bit two's complement) and the fixup flags.
// Per date the sequencer corrects the fields, walks the years from 1900,
// then the months from January, and adds the day, first for A, then for B;
// the single accumulator adds one year length or one month length per cycle.
// item_stall stays high from acceptance until the sequencer is back in idle,
// so the next item is taken in the cycle in which result_valid rises at the
// earliest; one item is in work at a time.
// The result sits in an output register: a new item may be taken while the
// last result still waits. If result_stall holds, the finished item waits in
// its last step until the output register is free.
// rst is synchronous and returns the sequencer to idle and drops result_valid.
// ----------------------------------------------------------------------------
module date_validate_and_day_difference (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dvdd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dvdd_pkg::result_t result
);

  dvdd_pkg::acc_ctrl_t        ctrl;
  logic [dvdd_pkg::ACC_W-1:0] acc;
  logic                       busy;
  logic                       done;
  logic                       start;
  logic                       out_free;
  dvdd_pkg::result_t          res;

  assign item_stall = busy;
  assign start      = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  dvdd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .out_free (out_free),
    .acc      (acc),
    .ctrl     (ctrl),
    .busy     (busy),
    .done     (done),
    .res      (res)
  );

  dvdd_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .acc  (acc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result <= res;
    end
  end

endmodule
